// File: hdl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared widths, state encoding and register indexes for the planar
// saturating spring force block.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int POS_W   = 32;  // Q16.16 positions and forces
  localparam int TRIG_W  = 16;  // Q2.14 cosine and sine
  localparam int CFG_W   = 31;  // widest configuration register
  localparam int MIND_W  = 16;  // min_distance register
  localparam int DIFF_W  = 33;  // position difference and its magnitude
  localparam int MAG_W   = 48;  // spring force magnitude and quotients
  localparam int MUL_A_W = 48;  // multiplicand, held parallel
  localparam int MUL_B_W = 33;  // multiplier, consumed one bit a cycle
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RAD_W   = 66;  // sum of squares
  localparam int ROOT_W  = 33;
  localparam int TERM_W  = 52;  // one rotated product after the Q2.14 shift
  localparam int SUM_W   = 53;  // sum of two rotated products
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 128;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REST_LENGTH  = 2'd0;
  localparam cfg_idx_t CFG_STIFFNESS    = 2'd1;
  localparam cfg_idx_t CFG_SATURATION   = 2'd2;
  localparam cfg_idx_t CFG_MIN_DISTANCE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_MAG,
    S_QXM,
    S_QXD,
    S_QYM,
    S_QYD,
    S_ROT,
    S_DONE
  } psf_state_t;

endpackage

// File: hdl/psf_mul.sv
// ----------------------------------------------------------------------------
// psf_mul
// Unsigned bit-serial shift-add multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module psf_mul import psf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0]  mcand_r;
  logic [PROD_W-1:0]  prod_r;
  logic [MUL_B_W-1:0] mplier_r;
  logic [5:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 6'(MUL_B_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(MUL_B_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= {{MUL_B_W{1'b0}}, a};
      mplier_r <= b;
      prod_r   <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// File: hdl/psf_sqrt.sv
// ----------------------------------------------------------------------------
// psf_sqrt
// Integer square root, restoring form, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module psf_sqrt import psf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]    rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [5:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                fits;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 6'(ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(ROOT_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (fits) begin
        rem_r  <= (ROOT_W+2)'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[ROOT_W+1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hdl/psf_div.sv
// ----------------------------------------------------------------------------
// psf_div
// Unsigned restoring divider, one quotient bit a cycle over the full
// dividend; the quotient is known to fit the force magnitude width.
// ----------------------------------------------------------------------------
module psf_div import psf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [DIFF_W-1:0] den,
  output logic              done,
  output logic [MAG_W-1:0]  quot
);

  logic [PROD_W-1:0] num_r;
  logic [DIFF_W-1:0] den_r;
  logic [DIFF_W-1:0] rem_r;
  logic [MAG_W-1:0]  quot_r;
  logic [6:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIFF_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, num_r[PROD_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 7'(PROD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(PROD_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= num_r << 1;
      quot_r <= {quot_r[MAG_W-2:0], fits};
      if (fits) rem_r <= DIFF_W'(rem_sh - {1'b0, den_r});
      else      rem_r <= rem_sh[DIFF_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: hdl/planar_saturating_spring_force.sv
// ----------------------------------------------------------------------------
// planar_saturating_spring_force
// Spring force between two planar anchors, rotated into each anchor frame
// and summed into saturating force accumulators.
// ----------------------------------------------------------------------------
// Input beats (in_*) carry both anchor positions and orientations; in_tuser
// selects apply (0) or clear (1). Every input beat yields exactly one output
// beat (out_*) holding the four accumulators and two status flags.
// A clear goes straight to the finish state. An apply runs through one
// shared bit-serial multiplier, a two-bit-per-cycle square root and a
// one-bit-per-cycle divider: an apply with anchors too close ends after the
// root, and any other apply takes the thirteen multiplier passes, the root
// and the two divides. One item is in work at a time; in_tready is high only
// while the block is idle. A finished result sits in the output register; if
// the receiver stalls, the next input beat is still taken and computed, and
// its result waits until the output register frees up.
// Reset clears the accumulators to zero and loads the register defaults
// (rest length 1.0, stiffness 1.0, no saturation, min distance 1 LSB).
// Configuration writes are taken at any edge with cfg_we high and must be
// issued only while the block is idle.
// ----------------------------------------------------------------------------
module planar_saturating_spring_force import psf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_pos_x, first_pos_y, second_pos_x, second_pos_y,
  // first_cos, first_sin, second_cos, second_sin
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // first_force_x, first_force_y, second_force_x, second_force_y
  output logic [OUT_DATA_W-1:0] out_tdata,
  // was_clamped, too_close
  output logic [1:0]            out_tuser,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  psf_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  rest_r, stiff_r, sat_r;
  logic [MIND_W-1:0] mind_r;

  logic              cmd_r;
  logic [POS_W-1:0]  p1x_r, p1y_r, p2x_r, p2y_r;
  logic [TRIG_W-1:0] c1_r, s1_r, c2_r, s2_r;

  logic [POS_W-1:0]  ffx_r, ffy_r, sfx_r, sfy_r;
  logic              out_valid_r;
  logic              out_clamped_r, out_close_r;
  logic              clamped_r, close_r;

  logic [RAD_W-2:0]  sx_r;
  logic [ROOT_W-1:0] len_r;
  logic              neg_r;
  logic [MAG_W-1:0]  mag_r, qx_r, qy_r;
  logic [2:0]        k_r;
  logic [SUM_W-1:0]  l1x_r, l1y_r, l2x_r, l2y_r;

  // shared unit hookup
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic               sqrt_start, sqrt_done;
  logic [RAD_W-1:0]   sqrt_rad;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               div_start, div_done;
  logic [MAG_W-1:0]   div_quot;

  logic [DIFF_W-1:0] dx, dy, ax, ay;
  logic [DIFF_W-1:0] rest_ext;
  logic              root_neg;
  logic [DIFF_W-1:0] dm;
  logic              root_close;
  logic [MAG_W-1:0]  mag_raw;
  logic              clamp_hit;
  logic [MAG_W-1:0]  mag_use;
  logic [2:0]        rot_k;
  logic [TRIG_W-1:0] rot_coef;
  logic [TRIG_W-1:0] rot_abs;
  logic [TRIG_W-1:0] cur_coef;
  logic              cur_neg;
  logic [RAD_W-1:0]  term_full;
  logic [TERM_W-1:0] term;
  logic              out_free;

  function automatic logic [TRIG_W-1:0] coef_of(input logic [2:0] k,
                                                input logic [TRIG_W-1:0] c1,
                                                input logic [TRIG_W-1:0] s1,
                                                input logic [TRIG_W-1:0] c2,
                                                input logic [TRIG_W-1:0] s2);
    logic [TRIG_W-1:0] r;
    case (k)
      3'd0, 3'd3: r = c1;
      3'd1, 3'd2: r = s1;
      3'd4, 3'd7: r = c2;
      default:    r = s2;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] acc,
                                               input logic [SUM_W-1:0] v,
                                               input logic sub);
    logic signed [SUM_W:0] ve;
    logic signed [SUM_W:0] s;
    logic [POS_W-1:0]      r;
    ve = $signed({v[SUM_W-1], v});
    s  = $signed({{(SUM_W-POS_W+1){acc[POS_W-1]}}, acc}) + (sub ? -ve : ve);
    if (s > $signed((SUM_W+1)'(32'h7FFF_FFFF)))
      r = 32'h7FFF_FFFF;
    else if (s < -$signed((SUM_W+1)'(33'h0_8000_0000)))
      r = 32'h8000_0000;
    else
      r = s[POS_W-1:0];
    return r;
  endfunction

  psf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  psf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  psf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_prod),
    .den   (len_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // geometry and magnitude helpers
  assign dx = {p1x_r[POS_W-1], p1x_r} - {p2x_r[POS_W-1], p2x_r};
  assign dy = {p1y_r[POS_W-1], p1y_r} - {p2y_r[POS_W-1], p2y_r};
  assign ax = dx[DIFF_W-1] ? -dx : dx;
  assign ay = dy[DIFF_W-1] ? -dy : dy;

  assign sqrt_rad   = {1'b0, sx_r} + {1'b0, mul_prod[RAD_W-2:0]};
  assign rest_ext   = {2'b00, rest_r};
  assign root_neg   = sqrt_root < rest_ext;
  assign dm         = root_neg ? rest_ext - sqrt_root : sqrt_root - rest_ext;
  assign root_close = sqrt_root <= {{(ROOT_W-MIND_W){1'b0}}, mind_r};

  assign mag_raw   = mul_prod[MAG_W+15:16];
  assign clamp_hit = (sat_r != '0) && (mag_raw > {{(MAG_W-CFG_W){1'b0}}, sat_r});
  assign mag_use   = clamp_hit ? {{(MAG_W-CFG_W){1'b0}}, sat_r} : mag_raw;

  // next rotation product operands
  assign rot_k    = (state_r == S_ROT) ? k_r + 3'd1 : 3'd0;
  assign rot_coef = coef_of(rot_k, c1_r, s1_r, c2_r, s2_r);
  assign rot_abs  = rot_coef[TRIG_W-1] ? -rot_coef : rot_coef;

  // finished rotation product, signed and shifted down by 14
  assign cur_coef  = coef_of(k_r, c1_r, s1_r, c2_r, s2_r);
  assign cur_neg   = cur_coef[TRIG_W-1] ^ (k_r[0] ? (dy[DIFF_W-1] ^ neg_r)
                                                  : (dx[DIFF_W-1] ^ neg_r))
                     ^ (k_r[1:0] == 2'd2);
  assign term_full = cur_neg ? (RAD_W'(0) - {2'b00, mul_prod[63:0]})
                             : {2'b00, mul_prod[63:0]};
  assign term      = term_full[RAD_W-1:14];

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = in_tuser ? S_DONE : S_LOAD;
      end
      S_LOAD: begin
        mul_start = 1'b1;
        mul_a     = {{(MUL_A_W-DIFF_W){1'b0}}, ax};
        mul_b     = ax;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = {{(MUL_A_W-DIFF_W){1'b0}}, ay};
          mul_b     = ay;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        if (mul_done) begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          if (root_close) begin
            state_nxt = S_DONE;
          end else begin
            mul_start = 1'b1;
            mul_a     = {{(MUL_A_W-CFG_W){1'b0}}, stiff_r};
            mul_b     = dm;
            state_nxt = S_MAG;
          end
        end
      end
      S_MAG: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mag_use;
          mul_b     = ax;
          state_nxt = S_QXM;
        end
      end
      S_QXM: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = S_QXD;
        end
      end
      S_QXD: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = mag_r;
          mul_b     = ay;
          state_nxt = S_QYM;
        end
      end
      S_QYM: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = S_QYD;
        end
      end
      S_QYD: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = qx_r;
          mul_b     = {{(MUL_B_W-TRIG_W){1'b0}}, rot_abs};
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (mul_done) begin
          if (k_r == 3'd7) begin
            state_nxt = S_DONE;
          end else begin
            mul_start = 1'b1;
            mul_a     = rot_k[0] ? qy_r : qx_r;
            mul_b     = {{(MUL_B_W-TRIG_W){1'b0}}, rot_abs};
          end
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= CFG_W'(65536);
      stiff_r <= CFG_W'(65536);
      sat_r   <= '0;
      mind_r  <= MIND_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REST_LENGTH:  rest_r  <= cfg_wdata;
        CFG_STIFFNESS:    stiff_r <= cfg_wdata;
        CFG_SATURATION:   sat_r   <= cfg_wdata;
        CFG_MIN_DISTANCE: mind_r  <= cfg_wdata[MIND_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulators double as the output register; flags are held beside them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      out_clamped_r <= 1'b0;
      out_close_r   <= 1'b0;
      ffx_r         <= '0;
      ffy_r         <= '0;
      sfx_r         <= '0;
      sfy_r         <= '0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r   <= 1'b1;
        out_clamped_r <= clamped_r & ~cmd_r;
        out_close_r   <= close_r & ~cmd_r;
        if (cmd_r) begin
          ffx_r <= '0;
          ffy_r <= '0;
          sfx_r <= '0;
          sfy_r <= '0;
        end else if (!close_r) begin
          ffx_r <= sat_add(ffx_r, l1x_r, 1'b1);
          ffy_r <= sat_add(ffy_r, l1y_r, 1'b1);
          sfx_r <= sat_add(sfx_r, l2x_r, 1'b0);
          sfy_r <= sat_add(sfy_r, l2y_r, 1'b0);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r     <= in_tuser;
      p1x_r     <= in_tdata[31:0];
      p1y_r     <= in_tdata[63:32];
      p2x_r     <= in_tdata[95:64];
      p2y_r     <= in_tdata[127:96];
      c1_r      <= in_tdata[143:128];
      s1_r      <= in_tdata[159:144];
      c2_r      <= in_tdata[175:160];
      s2_r      <= in_tdata[191:176];
      clamped_r <= 1'b0;
      close_r   <= 1'b0;
      l1x_r     <= '0;
      l1y_r     <= '0;
      l2x_r     <= '0;
      l2y_r     <= '0;
    end
    if (state_r == S_SQX && mul_done) sx_r <= mul_prod[RAD_W-2:0];
    if (state_r == S_SQRT && sqrt_done) begin
      len_r   <= sqrt_root;
      neg_r   <= root_neg;
      close_r <= root_close;
    end
    if (state_r == S_MAG && mul_done) begin
      mag_r     <= mag_use;
      clamped_r <= clamp_hit;
    end
    if (state_r == S_QXD && div_done) qx_r <= div_quot;
    if (state_r == S_QYD && div_done) begin
      qy_r <= div_quot;
      k_r  <= 3'd0;
    end
    if (state_r == S_ROT && mul_done) begin
      k_r <= k_r + 3'd1;
      case (k_r[2:1])
        2'd0:    l1x_r <= l1x_r + {term[TERM_W-1], term};
        2'd1:    l1y_r <= l1y_r + {term[TERM_W-1], term};
        2'd2:    l2x_r <= l2x_r + {term[TERM_W-1], term};
        default: l2y_r <= l2y_r + {term[TERM_W-1], term};
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sfy_r, sfx_r, ffy_r, ffx_r};
  assign out_tuser  = {out_close_r, out_clamped_r};

  // a new result appears only when an item has just finished
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the finish state");

  // a separation that was too close never reaches the clamp
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("clamped and too close flagged together");

  // multiplier completions only land where a product is awaited
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_SQX || state_r == S_SQY || state_r == S_MAG ||
                  state_r == S_QXM || state_r == S_QYM || state_r == S_ROT))
    else $error("multiplier finished with no consumer");

endmodule

// File: tb/sv/planar_saturating_spring_force_tb.sv
// ----------------------------------------------------------------------------
// planar_saturating_spring_force_tb
// Self-checking bench for the planar spring force block. A directed table and
// several phases of random beats run under different register settings. Each
// result beat is compared with a bit-exact prediction of the accumulators and
// flags, or with the beat given in the table for a typed row. Both stream
// sides idle at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module planar_saturating_spring_force_tb import psf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] p1x, p1y, p2x, p2y;
    logic signed [15:0] c1, s1, c2, s2;
  } spring_beat_t;

  typedef struct packed {
    logic signed [31:0] f1x, f1y, f2x, f2y;
    logic               clamped, close;
  } force_beat_t;

  typedef struct packed {
    logic         typed;
    spring_beat_t b;
    force_beat_t  e;
  } table_row_t;

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam int   HOLDOFF_CYCLES = 3000;
  localparam int   STALL_LIMIT    = 20000;
  localparam int   PHASE_BEATS    = 190;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_REST_LENGTH;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // predictor state
  logic [30:0]        rest_q, stiff_q, sat_q;
  logic [15:0]        mind_q;
  logic signed [31:0] acc1[2], acc2[2];

  force_beat_t expq[$];
  table_row_t  dir_rows[$];
  int          err_cnt = 0;
  int          stall_cnt = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  planar_saturating_spring_force i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic signed [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // inverse rotation of the world force into an anchor frame
  function automatic void to_frame(input logic signed [15:0] c, s,
                                   input logic signed [127:0] fx, fy,
                                   output logic signed [127:0] lx, ly);
    logic signed [127:0] cw, sw;
    cw = c;
    sw = s;
    lx = ((cw * fx) >>> 14) + ((sw * fy) >>> 14);
    ly = (((-sw) * fx) >>> 14) + ((cw * fy) >>> 14);
  endfunction

  function automatic force_beat_t spring_step(spring_beat_t b);
    longint              dx, dy;
    logic [32:0]         ax, ay, len, cand, dm;
    logic [66:0]         rad;
    logic [63:0]         mag;
    logic [127:0]        qx, qy;
    logic signed [127:0] fx, fy, l1x, l1y, l2x, l2y;
    logic                neg;
    force_beat_t         r;
    r = '0;
    if (b.cmd == CMD_CLEAR) begin
      acc1[0] = 0; acc1[1] = 0; acc2[0] = 0; acc2[1] = 0;
    end else begin
      dx = longint'(b.p1x) - longint'(b.p2x);
      dy = longint'(b.p1y) - longint'(b.p2y);
      ax = 33'(dx < 0 ? -dx : dx);
      ay = 33'(dy < 0 ? -dy : dy);
      rad = 67'(ax) * 67'(ax) + 67'(ay) * 67'(ay);
      len = '0;
      for (int k = 32; k >= 0; k--) begin
        cand = len | (33'd1 << k);
        if (67'(cand) * 67'(cand) <= rad) len = cand;
      end
      if (len <= 33'(mind_q)) begin
        r.close = 1'b1;
      end else begin
        neg = len < 33'(rest_q);
        dm = neg ? 33'(rest_q) - len : len - 33'(rest_q);
        mag = (64'(dm) * 64'(stiff_q)) >> 16;
        if (sat_q != 0 && mag > 64'(sat_q)) begin
          mag = 64'(sat_q);
          r.clamped = 1'b1;
        end
        qx = (128'(ax) * 128'(mag)) / 128'(len);
        qy = (128'(ay) * 128'(mag)) / 128'(len);
        fx = ((dx < 0) != neg) ? -$signed(qx) : $signed(qx);
        fy = ((dy < 0) != neg) ? -$signed(qy) : $signed(qy);
        to_frame(b.c1, b.s1, fx, fy, l1x, l1y);
        to_frame(b.c2, b.s2, fx, fy, l2x, l2y);
        acc1[0] = sat32(128'(acc1[0]) - l1x);
        acc1[1] = sat32(128'(acc1[1]) - l1y);
        acc2[0] = sat32(128'(acc2[0]) + l2x);
        acc2[1] = sat32(128'(acc2[1]) + l2y);
      end
    end
    r.f1x = acc1[0]; r.f1y = acc1[1]; r.f2x = acc2[0]; r.f2y = acc2[1];
    return r;
  endfunction

  task automatic send_beat(input spring_beat_t b, input logic typed, input force_beat_t e);
    force_beat_t p;
    if (!quiet && $urandom_range(99) < 18) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(40)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = b.cmd;
    in_tdata  = {b.s2, b.c2, b.s1, b.c1, b.p2y, b.p2x, b.p1y, b.p1x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = spring_step(b);
    expq.push_back(typed ? e : p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expq.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_REST_LENGTH:  rest_q  = val;
      CFG_STIFFNESS:    stiff_q = val;
      CFG_SATURATION:   sat_q   = val;
      CFG_MIN_DISTANCE: mind_q  = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(200 << 16)) - (32'sd100 << 16);
      default: return 32'($urandom_range(16)) - 32'sd8;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_trig();
    if ($urandom_range(99) < 20) return 16'($urandom());
    return 16'($urandom_range(32768)) - 16'sd16384;
  endfunction

  function automatic spring_beat_t rand_beat();
    spring_beat_t b;
    int sel;
    sel = $urandom_range(99);
    b.cmd = (sel < 8) ? CMD_CLEAR : CMD_APPLY;
    b.p1x = rand_pos(sel < 30 ? 0 : 1);
    b.p1y = rand_pos(sel < 30 ? 0 : 1);
    if (sel >= 30 && sel < 80) begin
      // neighbor within a few units
      b.p2x = b.p1x + 32'($urandom_range(8 << 16)) - (32'sd4 << 16);
      b.p2y = b.p1y + 32'($urandom_range(8 << 16)) - (32'sd4 << 16);
    end else if (sel >= 80 && sel < 90) begin
      b.p2x = b.p1x + rand_pos(2);
      b.p2y = b.p1y + rand_pos(2);
    end else begin
      b.p2x = rand_pos(sel < 30 ? 0 : 1);
      b.p2y = rand_pos(sel < 30 ? 0 : 1);
    end
    b.c1 = rand_trig(); b.s1 = rand_trig();
    b.c2 = rand_trig(); b.s2 = rand_trig();
    return b;
  endfunction

  task automatic random_config();
    write_reg(CFG_REST_LENGTH, $urandom_range(99) < 15 ? 31'($urandom())
                                                       : 31'($urandom_range(4 << 16)));
    write_reg(CFG_STIFFNESS, $urandom_range(99) < 15 ? 31'($urandom())
                                                     : 31'($urandom_range(8 << 16)));
    write_reg(CFG_SATURATION, $urandom_range(1) ? 31'd0
                                                : 31'($urandom_range(1, 2 << 16)));
    write_reg(CFG_MIN_DISTANCE, $urandom_range(99) < 20 ? 31'($urandom_range(65535))
                                                        : 31'($urandom_range(64)));
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_tready = quiet || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    force_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
             out_tuser[0], out_tuser[1]};
      if (expq.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expq.pop_front();
        if (want != got) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: exp f1=(%0d,%0d) f2=(%0d,%0d) clamp=%0b close=%0b",
                      " | got f1=(%0d,%0d) f2=(%0d,%0d) clamp=%0b close=%0b"},
                     want.f1x, want.f1y, want.f2x, want.f2y, want.clamped, want.close,
                     got.f1x, got.f1y, got.f2x, got.f2y, got.clamped, got.close);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("planar_saturating_spring_force_tb: errors");
      $finish;
    end
  end

  initial begin
    rest_q = 31'd65536; stiff_q = 31'd65536; sat_q = '0; mind_q = 16'd1;
    acc1[0] = 0; acc1[1] = 0; acc2[0] = 0; acc2[1] = 0;

    dir_rows.push_back('{1'b1, '{CMD_CLEAR, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                        16'sd0, 16'sd0, 16'sd0, 16'sd0}, '0});
    dir_rows.push_back('{1'b1, '{CMD_APPLY, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                        16'sd16384, 16'sd0, 16'sd16384, 16'sd0},
                        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1}});
    dir_rows.push_back('{1'b1, '{CMD_APPLY, 32'sd1, 32'sd0, 32'sd0, 32'sd0,
                        16'sd16384, 16'sd0, 16'sd16384, 16'sd0},
                        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1}});
    dir_rows.push_back('{1'b1, '{CMD_APPLY, 32'sh10000, 32'sd0, 32'sd0, 32'sd0,
                        16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, '0});
    dir_rows.push_back('{1'b0, '{CMD_APPLY, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh80000000, 32'sh80000000,
                        16'sd16384, 16'sd0, -16'sd16384, 16'sd16384}, '0});
    dir_rows.push_back('{1'b0, '{CMD_APPLY, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh7fffffff,
                        16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}, '0});
    dir_rows.push_back('{1'b0, '{CMD_APPLY, 32'sh30000, 32'sd0, 32'sd0, 32'sd0,
                        16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, '0});
    dir_rows.push_back('{1'b0, '{CMD_APPLY, 32'sd0, 32'sh8000, 32'sd0, 32'sd0,
                        16'sd0, 16'sd16384, 16'sd0, -16'sd16384}, '0});
    dir_rows.push_back('{1'b0, '{CMD_APPLY, -32'sh20000, 32'sh10000,
                        32'sh10000, -32'sh10000,
                        16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585}, '0});
    dir_rows.push_back('{1'b0, '{CMD_APPLY, 32'sh00c80000, -32'sh00640000,
                        -32'sh01000000, 32'sh00030000,
                        16'shffff, 16'sh0001, 16'sh4000, 16'shc000}, '0});
    dir_rows.push_back('{1'b1, '{CMD_CLEAR, 32'sh12345678, -32'sd5, 32'sd7, 32'sd0,
                        16'sd0, 16'sd0, 16'sd0, 16'sd0}, '0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].e);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_REST_LENGTH, 31'd0);
          write_reg(CFG_STIFFNESS, 31'h7fffffff);
          write_reg(CFG_SATURATION, 31'd1);
          write_reg(CFG_MIN_DISTANCE, 31'd0);
        end
        1: begin
          write_reg(CFG_REST_LENGTH, 31'h7fffffff);
          write_reg(CFG_STIFFNESS, 31'd65536);
          write_reg(CFG_SATURATION, 31'h7fffffff);
          write_reg(CFG_MIN_DISTANCE, 31'd65535);
        end
        default: random_config();
      endcase
      quiet = (ph == 3);
      hold_req = (ph == 4);
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(rand_beat(), 1'b0, '0);
    end

    drain();
    quiet = 1'b0;
    repeat (700) @(posedge clk);
    if (err_cnt == 0) begin
      $display("planar_saturating_spring_force_tb: clean");
    end else begin
      $display("planar_saturating_spring_force_tb: errors");
    end
    $finish;
  end

endmodule

// File: planar_saturating_spring_force.f
hdl/psf_pkg.sv
hdl/psf_mul.sv
hdl/psf_sqrt.sv
hdl/psf_div.sv
hdl/planar_saturating_spring_force.sv
tb/sv/planar_saturating_spring_force_tb.sv
